// ===== hw/rtl/wma_pkg.sv =====
// wma_pkg: shared constants, types and state codes of the weighted moving average
// no dependencies; used by wma_cfg, wma_ctrl, wma_dp and weighted_moving_average

package wma_pkg;

  // window and field sizes
  localparam int TAPS       = 8;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W      = 35;
  localparam int AVG_W      = 35;
  localparam int WSUM_W     = WEIGHT_W + 4;
  localparam int CNT_W      = 4;
  localparam int TAP_IW     = (TAPS > 1) ? $clog2(TAPS) : 1;

  // divider: magnitude of the sum fits in ACC_W-1 bits
  localparam int QUO_W      = ACC_W - 1;
  localparam int REM_W      = WSUM_W;
  localparam int DIV_CW     = $clog2(QUO_W);

  // stream and register port sizes
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((AVG_W + 7) / 8) * 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;

  // register indexes (byte address / 8)
  localparam logic [1:0] REG_TAPS   = 2'd0;
  localparam logic [1:0] REG_W_LOW  = 2'd1;
  localparam logic [1:0] REG_W_HIGH = 2'd2;

  localparam logic [CNT_W-1:0]      TAPS_RST = CNT_W'(TAPS);
  localparam logic [CFG_DATA_W-1:0] W_RST    = 64'h0001_0001_0001_0001;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FLUSH,
    ST_DIVSET,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]      taps;
    logic [CFG_DATA_W-1:0] w_low;
    logic [CFG_DATA_W-1:0] w_high;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_setup;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic window_full;
    logic last_tap;
    logic wsum_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/weighted_moving_average.sv =====
// weighted_moving_average: top level, register bank, sequencer and datapath
// depends on wma_pkg, wma_cfg, wma_ctrl, wma_dp
//
//  channel  | dir | bits                               | handshake
//  in_      | in  | tdata[15:0] sample, tuser restart  | tvalid/tready
//  out_     | out | tdata[34:0] average, tuser wsz     | tvalid/tready
//  cfg_     | in  | apb, 64-bit data, regs at 8*index  | psel/penable, pready high
//
// an item passes from acceptance through the window check, one multiply-accumulate per tap in use,
// a flush, the divider setup and 34 divider steps into the result register;
// a zero weight sum skips the divider, an item with the window not yet full gives no result.
// one item at a time; the next is taken while a result still waits in the output register.
// a result stalled on out_tready holds the sequencer before its hand-off.
// synchronous active-low reset clears window, fill count and registers to defaults.

module weighted_moving_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wma_pkg::IN_TDATA_W-1:0]       in_tdata,   // [15:0] sample
  input  logic                                 in_tuser,   // [0] restart
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wma_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [34:0] average, [39:35] zero
  output logic                                 out_tuser,  // [0] weight_sum_zero
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [wma_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [wma_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [wma_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  wma_pkg::cfg_t                    cfg;
  wma_pkg::cmd_t                    cmd;
  wma_pkg::sts_t                    sts;
  wma_pkg::state_t                  state;
  logic signed [wma_pkg::AVG_W-1:0] average;

  wma_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  wma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  wma_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_sample     (in_tdata[wma_pkg::SAMPLE_W-1:0]),
    .in_restart    (in_tuser),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_average   (average),
    .out_wsum_zero (out_tuser)
  );

  assign out_tdata = wma_pkg::OUT_TDATA_W'($unsigned(average));

`ifndef SYNTH
  // a zero weight sum always comes with a zero average
  a_wsz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[wma_pkg::AVG_W-1:0] == '0)
    else $error("weight_sum_zero result with nonzero average");

  // an accepted item always moves the sequencer out of idle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state == wma_pkg::ST_CHECK)
    else $error("sequencer did not start on accepted item");

  // last divider step hands over to the result stage
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state == wma_pkg::ST_DIV && sts.div_last |=> state == wma_pkg::ST_DONE)
    else $error("divider did not finish after its last step");

  // hand-off only into a free output register
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_tvalid || out_tready)
    else $error("result written over a waiting item");
`endif

endmodule

// ===== hw/rtl/wma_cfg.sv =====
// wma_cfg: register bank behind the apb-style configuration port
// depends on wma_pkg

module wma_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wma_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wma_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wma_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output wma_pkg::cfg_t                     cfg_o
);

  logic [wma_pkg::CNT_W-1:0]      taps_r;
  logic [wma_pkg::CFG_DATA_W-1:0] w_low_r;
  logic [wma_pkg::CFG_DATA_W-1:0] w_high_r;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[4:3];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r   <= wma_pkg::TAPS_RST;
      w_low_r  <= wma_pkg::W_RST;
      w_high_r <= wma_pkg::W_RST;
    end else if (wr_en) begin
      case (reg_idx)
        wma_pkg::REG_TAPS:   taps_r   <= pwdata[wma_pkg::CNT_W-1:0];
        wma_pkg::REG_W_LOW:  w_low_r  <= pwdata;
        wma_pkg::REG_W_HIGH: w_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wma_pkg::REG_TAPS:   prdata = wma_pkg::CFG_DATA_W'(taps_r);
      wma_pkg::REG_W_LOW:  prdata = w_low_r;
      wma_pkg::REG_W_HIGH: prdata = w_high_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.taps   = taps_r;
  assign cfg_o.w_low  = w_low_r;
  assign cfg_o.w_high = w_high_r;

endmodule

// ===== hw/rtl/wma_ctrl.sv =====
// wma_ctrl: sequencer for load, multiply-accumulate, divide and result hand-off
// depends on wma_pkg

module wma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wma_pkg::sts_t     sts_i,
  output wma_pkg::cmd_t     cmd_o,
  output wma_pkg::state_t   state_o
);

  wma_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      wma_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd_o.load = in_tvalid;
        if (in_tvalid) state_nxt = wma_pkg::ST_CHECK;
      end
      wma_pkg::ST_CHECK: begin
        // too few samples since restart: item gives no result
        state_nxt = sts_i.window_full ? wma_pkg::ST_MUL : wma_pkg::ST_IDLE;
      end
      wma_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.last_tap) state_nxt = wma_pkg::ST_FLUSH;
      end
      wma_pkg::ST_FLUSH: begin
        // last product still in flight into the accumulator
        state_nxt = wma_pkg::ST_DIVSET;
      end
      wma_pkg::ST_DIVSET: begin
        cmd_o.div_setup = 1'b1;
        state_nxt = sts_i.wsum_zero ? wma_pkg::ST_DONE : wma_pkg::ST_DIV;
      end
      wma_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_nxt = wma_pkg::ST_DONE;
      end
      wma_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = wma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wma_pkg::ST_IDLE;
    endcase
  end

  assign state_o = state_r;

endmodule

// ===== hw/rtl/wma_dp.sv =====
// wma_dp: sample window, serial multiply-accumulate, restoring divider, output register
// depends on wma_pkg; driven by wma_ctrl commands

module wma_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wma_pkg::cfg_t                         cfg_i,
  input  wma_pkg::cmd_t                         cmd_i,
  output wma_pkg::sts_t                         sts_o,
  input  logic signed [wma_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                  in_restart,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic signed [wma_pkg::AVG_W-1:0]      out_average,
  output logic                                  out_wsum_zero
);

  localparam int CW = wma_pkg::CNT_W;

  logic signed [wma_pkg::SAMPLE_W-1:0] win_r [wma_pkg::TAPS];
  logic [CW-1:0]                       fill_r;
  logic [CW-1:0]                       n_r;
  logic [wma_pkg::TAP_IW-1:0]          idx_r;
  logic signed [wma_pkg::PROD_W-1:0]   prod_r;
  logic                                prod_vld_r;
  logic signed [wma_pkg::ACC_W-1:0]    acc_r;
  logic signed [wma_pkg::WSUM_W-1:0]   wsum_r;
  logic [wma_pkg::REM_W-1:0]           rem_r;
  logic [wma_pkg::QUO_W-1:0]           quo_r;
  logic [wma_pkg::REM_W-1:0]           dvs_r;
  logic                                neg_r;
  logic                                zero_r;
  logic [wma_pkg::DIV_CW-1:0]          div_cnt_r;
  logic                                out_vld_r;
  logic signed [wma_pkg::AVG_W-1:0]    out_avg_r;
  logic                                out_wsz_r;

  logic [CW-1:0]                       n_eff;
  logic [CW-1:0]                       fill_base;
  logic [CW-1:0]                       fill_nxt;
  logic [CW-1:0]                       win_idx;
  logic [2*wma_pkg::CFG_DATA_W-1:0]    w_all;
  logic signed [wma_pkg::WEIGHT_W-1:0] weight;
  logic signed [wma_pkg::SAMPLE_W-1:0] samp;
  logic signed [wma_pkg::ACC_W-1:0]    acc_abs;
  logic signed [wma_pkg::WSUM_W-1:0]   wsum_abs;
  logic [wma_pkg::REM_W-1:0]           trial;
  logic                                ge;
  logic [wma_pkg::QUO_W:0]             quo_ext;

  // zero taps counts as one, more than the window as the full window
  always_comb begin
    if (cfg_i.taps == '0) n_eff = CW'(1);
    else if (cfg_i.taps > CW'(wma_pkg::TAPS)) n_eff = CW'(wma_pkg::TAPS);
    else n_eff = cfg_i.taps;
  end

  assign fill_base = in_restart ? '0 : fill_r;
  assign fill_nxt  = (fill_base < CW'(wma_pkg::TAPS)) ? fill_base + CW'(1) : fill_base;

  // newest n samples sit at the top of the window
  assign win_idx = CW'(wma_pkg::TAPS) - n_r + CW'(idx_r);
  assign samp    = win_r[win_idx[wma_pkg::TAP_IW-1:0]];
  assign w_all   = {cfg_i.w_high, cfg_i.w_low};
  assign weight  = w_all[idx_r*wma_pkg::WEIGHT_W +: wma_pkg::WEIGHT_W];

  assign acc_abs  = acc_r[wma_pkg::ACC_W-1] ? -acc_r : acc_r;
  assign wsum_abs = wsum_r[wma_pkg::WSUM_W-1] ? -wsum_r : wsum_r;

  assign trial   = {rem_r[wma_pkg::REM_W-2:0], quo_r[wma_pkg::QUO_W-1]};
  assign ge      = trial >= dvs_r;
  assign quo_ext = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      n_r    <= n_eff;
      idx_r  <= '0;
      acc_r  <= '0;
      wsum_r <= '0;
    end
    if (cmd_i.mul) begin
      prod_r <= samp * weight;
      wsum_r <= wsum_r + wma_pkg::WSUM_W'(weight);
      idx_r  <= idx_r + wma_pkg::TAP_IW'(1);
    end
    if (prod_vld_r) acc_r <= acc_r + wma_pkg::ACC_W'(prod_r);
    if (cmd_i.div_setup) begin
      neg_r     <= acc_r[wma_pkg::ACC_W-1] ^ wsum_r[wma_pkg::WSUM_W-1];
      zero_r    <= (wsum_r == '0);
      quo_r     <= acc_abs[wma_pkg::QUO_W-1:0];
      dvs_r     <= wsum_abs;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd_i.div_step) begin
      rem_r     <= ge ? trial - dvs_r : trial;
      quo_r     <= {quo_r[wma_pkg::QUO_W-2:0], ge};
      div_cnt_r <= div_cnt_r + wma_pkg::DIV_CW'(1);
    end
    if (cmd_i.emit) begin
      out_wsz_r <= zero_r;
      if (zero_r) out_avg_r <= '0;
      else if (neg_r) out_avg_r <= -$signed(quo_ext);
      else out_avg_r <= $signed(quo_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wma_pkg::TAPS; i++) win_r[i] <= '0;
      fill_r     <= '0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < wma_pkg::TAPS - 1; i++) win_r[i] <= win_r[i+1];
        win_r[wma_pkg::TAPS-1] <= in_sample;
        fill_r <= fill_nxt;
      end
      prod_vld_r <= cmd_i.mul;
      if (cmd_i.emit) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  assign sts_o.window_full = fill_r >= n_r;
  assign sts_o.last_tap    = CW'(idx_r) == n_r - CW'(1);
  assign sts_o.wsum_zero   = wsum_r == '0;
  assign sts_o.div_last    = div_cnt_r == wma_pkg::DIV_CW'(wma_pkg::QUO_W - 1);
  assign sts_o.out_free    = !out_vld_r || out_tready;

  assign out_tvalid    = out_vld_r;
  assign out_average   = out_avg_r;
  assign out_wsum_zero = out_wsz_r;

endmodule

// ===== tb/weighted_moving_average_test.sv =====
`timescale 1ns / 1ps
// weighted_moving_average_test: self-checking bench for the weighted moving average block
// directed window, weight and tap-count cases, then random series with random idling
// depends on wma_pkg and weighted_moving_average

module weighted_moving_average_test;

  localparam int CLK_HALF_NS     = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_PHASES   = 20;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int REPORT_LIMIT    = 10;
  localparam longint TIMEOUT_NS  = 40_000_000;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    W_RANDOM,
    W_SMALL,
    W_EXTREME,
    W_ZERO_SUM,
    W_SMOOTH
  } weight_style_t;

  typedef struct packed {
    logic                             sum_zero;
    logic signed [wma_pkg::AVG_W-1:0] average;
  } average_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [wma_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;   // [15:0] sample
  logic                            in_tuser    = 1'b0; // [0] restart
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [wma_pkg::OUT_TDATA_W-1:0] out_tdata;          // [34:0] average, [39:35] zero
  logic                            out_tuser;          // [0] weight_sum_zero
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [wma_pkg::CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [wma_pkg::CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [wma_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  // own copy of the block's settings and window
  logic [wma_pkg::CNT_W-1:0]      taps_setting = wma_pkg::TAPS_RST;
  logic [wma_pkg::CFG_DATA_W-1:0] weights_lo_setting = wma_pkg::W_RST;
  logic [wma_pkg::CFG_DATA_W-1:0] weights_hi_setting = wma_pkg::W_RST;
  logic signed [wma_pkg::SAMPLE_W-1:0] window_copy [wma_pkg::TAPS];
  int                             fill_copy = 0;

  average_t pending_averages [$];
  int       mismatches = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;

  weighted_moving_average u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF_NS clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [63:0] expected,
                               input logic [63:0] actual);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s: expected %h, got %h", what, expected, actual);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic signed [wma_pkg::SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return wma_pkg::SAMPLE_W'($urandom);
    if (r == 7) return 16'sh7fff;
    if (r == 8) return 16'sh8000;
    return wma_pkg::SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
  endfunction

  function automatic logic [wma_pkg::CFG_DATA_W-1:0] pack_weights(
      input logic [wma_pkg::WEIGHT_W-1:0] w0, input logic [wma_pkg::WEIGHT_W-1:0] w1,
      input logic [wma_pkg::WEIGHT_W-1:0] w2, input logic [wma_pkg::WEIGHT_W-1:0] w3);
    return {w3, w2, w1, w0};
  endfunction

  // shift the item into the window copy and queue the average it gives, if any
  function automatic void predict_average(
      input logic signed [wma_pkg::SAMPLE_W-1:0] sample_value, input logic restart);
    int n;
    longint acc;
    longint wsum;
    longint quo;
    logic signed [wma_pkg::WEIGHT_W-1:0] w;
    average_t res;
    if (restart) fill_copy = 0;
    for (int i = 0; i < wma_pkg::TAPS - 1; i++) window_copy[i] = window_copy[i + 1];
    window_copy[wma_pkg::TAPS - 1] = sample_value;
    if (fill_copy < wma_pkg::TAPS) fill_copy++;
    n = int'(taps_setting);
    if (n == 0) n = 1;
    if (n > wma_pkg::TAPS) n = wma_pkg::TAPS;
    if (fill_copy < n) return;
    acc = 0;
    wsum = 0;
    for (int i = 0; i < n; i++) begin
      w = (i < 4) ? weights_lo_setting[16 * (i % 4) +: wma_pkg::WEIGHT_W]
                  : weights_hi_setting[16 * (i % 4) +: wma_pkg::WEIGHT_W];
      acc += longint'(window_copy[wma_pkg::TAPS - n + i]) * longint'(w);
      wsum += longint'(w);
    end
    if (wsum == 0) begin
      res.sum_zero = 1'b1;
      res.average = '0;
    end else begin
      quo = acc / wsum;
      res.sum_zero = 1'b0;
      res.average = quo[wma_pkg::AVG_W-1:0];
    end
    pending_averages = {pending_averages, res};
  endfunction

  // ready stalls on the result side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    average_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_averages.size() == 0) begin
        note_mismatch("unexpected result", '0, {out_tuser, out_tdata});
      end else begin
        want = pending_averages.pop_front();
        if (out_tuser !== want.sum_zero ||
            out_tdata !== wma_pkg::OUT_TDATA_W'($unsigned(want.average)))
          note_mismatch("result {wsz, tdata}",
                        {want.sum_zero, wma_pkg::OUT_TDATA_W'($unsigned(want.average))},
                        {out_tuser, out_tdata});
      end
    end
  end

  task automatic send_sample(input logic signed [wma_pkg::SAMPLE_W-1:0] sample_value,
                             input logic restart);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= wma_pkg::IN_TDATA_W'($unsigned(sample_value));
    in_tuser <= restart;
    do @(posedge clk); while (!in_tready);
    predict_average(sample_value, restart);
    if (idle_on) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index,
                                input logic [wma_pkg::CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (index)
      wma_pkg::REG_TAPS:   taps_setting = value[wma_pkg::CNT_W-1:0];
      wma_pkg::REG_W_LOW:  weights_lo_setting = value;
      wma_pkg::REG_W_HIGH: weights_hi_setting = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [wma_pkg::CFG_DATA_W-1:0] got;
    logic [wma_pkg::CFG_DATA_W-1:0] want;
    for (int i = 0; i < 3; i++) begin
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      cfg_paddr <= {2'(i), 3'b000};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      got = cfg_prdata;
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      case (2'(i))
        wma_pkg::REG_TAPS:  want = wma_pkg::CFG_DATA_W'(taps_setting);
        wma_pkg::REG_W_LOW: want = weights_lo_setting;
        default:            want = weights_hi_setting;
      endcase
      if (got !== want) note_mismatch("register read", want, got);
      @(posedge clk);
    end
  endtask

  // all-one weights over eight taps; the sum -4 over 8 must truncate to 0
  task automatic test_default_weights();
    check_registers();
    send_sample(16'sh7fff, 1'b1);
    repeat (3) send_sample(16'sh7fff, 1'b0);
    repeat (4) send_sample(16'sh8000, 1'b0);
  endtask

  task automatic test_zero_weight_sum();
    drain_results();
    write_register(wma_pkg::REG_TAPS, 64'd2);
    write_register(wma_pkg::REG_W_LOW, pack_weights(16'd5, -16'sd5, 16'd9, 16'd9));
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd200, 1'b0);
    send_sample(-16'sd300, 1'b0);
  endtask

  // zero taps acts as one tap
  task automatic test_tap_count_limits();
    drain_results();
    write_register(wma_pkg::REG_TAPS, 64'd0);
    write_register(wma_pkg::REG_W_LOW, pack_weights(16'd3, 16'd1, 16'd1, 16'd1));
    check_registers();
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // taps above eight saturate; weights sum to one so the average nears 2^33
  task automatic test_full_scale();
    drain_results();
    write_register(wma_pkg::REG_TAPS, 64'd15);
    write_register(wma_pkg::REG_W_LOW,
                   pack_weights(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    write_register(wma_pkg::REG_W_HIGH,
                   pack_weights(16'h7fff, 16'h8000, 16'h7fff, -16'sd32763));
    check_registers();
    for (int i = 0; i < wma_pkg::TAPS; i++)
      send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 0);
  endtask

  task automatic test_unused_register();
    drain_results();
    write_register(REG_UNUSED, {$urandom, $urandom});
    check_registers();
    send_sample(pick_sample(), 1'b0);
  endtask

  // the fill count survives a change of tap count
  task automatic test_taps_change_mid_series();
    drain_results();
    write_register(wma_pkg::REG_TAPS, 64'd3);
    write_register(wma_pkg::REG_W_LOW, pack_weights(16'd1, 16'd2, 16'd3, 16'd4));
    write_register(wma_pkg::REG_W_HIGH, pack_weights(16'd5, 16'd6, 16'd7, 16'd8));
    send_sample(16'sd1000, 1'b1);
    send_sample(-16'sd2000, 1'b0);
    send_sample(16'sd3001, 1'b0);
    drain_results();
    write_register(wma_pkg::REG_TAPS, 64'd5);
    send_sample(-16'sd77, 1'b0);
    send_sample(16'sd12345, 1'b0);
  endtask

  task automatic test_random_series();
    int taps_req;
    int eff;
    int sent;
    int run_len;
    int wsum;
    weight_style_t style;
    logic [wma_pkg::WEIGHT_W-1:0] wt [wma_pkg::TAPS];
    logic restart;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      idle_on = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 9))
        7:       taps_req = 0;
        8:       taps_req = $urandom_range(9, 15);
        9:       taps_req = wma_pkg::TAPS;
        default: taps_req = $urandom_range(1, wma_pkg::TAPS);
      endcase
      eff = (taps_req == 0) ? 1 : ((taps_req > wma_pkg::TAPS) ? wma_pkg::TAPS : taps_req);
      style = weight_style_t'($urandom_range(0, 4));
      for (int j = 0; j < wma_pkg::TAPS; j++) begin
        case (style)
          W_RANDOM:   wt[j] = wma_pkg::WEIGHT_W'($urandom);
          W_SMALL:    wt[j] = wma_pkg::WEIGHT_W'(int'($urandom_range(0, 8)) - 4);
          W_ZERO_SUM: wt[j] = wma_pkg::WEIGHT_W'(int'($urandom_range(0, 200)) - 100);
          W_SMOOTH:   wt[j] = wma_pkg::WEIGHT_W'($urandom_range(1, 100));
          default: begin
            case ($urandom_range(0, 4))
              0:       wt[j] = 16'h7fff;
              1:       wt[j] = 16'h8000;
              2:       wt[j] = 16'h0000;
              3:       wt[j] = 16'h0001;
              default: wt[j] = 16'hffff;
            endcase
          end
        endcase
      end
      if (style == W_ZERO_SUM) begin
        wsum = 0;
        for (int j = 0; j < eff - 1; j++) wsum += int'($signed(wt[j]));
        wt[eff - 1] = wma_pkg::WEIGHT_W'(-wsum);
      end
      write_register(wma_pkg::REG_TAPS, wma_pkg::CFG_DATA_W'(taps_req));
      write_register(wma_pkg::REG_W_LOW, pack_weights(wt[0], wt[1], wt[2], wt[3]));
      write_register(wma_pkg::REG_W_HIGH, pack_weights(wt[4], wt[5], wt[6], wt[7]));
      check_registers();
      // sometimes carry the previous series on across the new settings
      restart = ($urandom_range(0, 9) < 7);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 16);
        for (int j = 0; j < run_len && sent < ITEMS_PER_PHASE; j++) begin
          send_sample(pick_sample(), restart || ($urandom_range(0, 49) == 0));
          restart = 1'b0;
          sent++;
        end
        restart = 1'b1;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < wma_pkg::TAPS; i++) window_copy[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_default_weights();
    test_zero_weight_sum();
    test_tap_count_limits();
    test_full_scale();
    test_unused_register();
    test_taps_change_mid_series();
    test_random_series();
    drain_results();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
